// ===== rtl/core/prff_pkg.sv =====
// Shared types, constants and helpers for the partial-read frame FIFO.
// Used by prff_ctrl, prff_dp and partial_read_frame_fifo; no dependencies.
`default_nettype none
package prff_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ADDR_BITS   = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W       = 16;
  localparam int MAX_W       = 24;
  localparam int OCC_W       = 25;
  localparam int MODE_W      = 2;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [MAX_W-1:0] MAX_BYTES_RESET = 24'd1048576;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_BYTES = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ   = 2'd0,
    MODE_DEQ   = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic capture;   // latch the incoming word
    logic exec;      // apply it to the queue and load the result register
  } cmd_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/partial_read_frame_fifo.sv =====
// Top level of the partial-read frame FIFO: APB register, sequencer and
// datapath. Depends on prff_pkg, prff_ctrl and prff_dp.
`default_nettype none
// Queue of up to QUEUE_DEPTH frame descriptors (buffer address, byte length)
// with a running byte count. Each input word carries a mode: enqueue stores
// a descriptor if pushing is enabled, the address and length are non-zero
// and a slot is free; dequeue hands out up to need_len bytes of the head
// frame, returning head address plus the current read offset, and pops the
// frame once its remainder is used up; flush empties the queue. Enqueues
// stop once the byte count reaches max_buffer_bytes (APB, byte address 0)
// and resume on a pop or flush. Every word yields exactly one result word.
// Each word is captured while the head descriptor is read from the
// registered-output descriptor memory, then updates the queue and loads
// the output register; the input stalls until that update is done. The
// next word is taken while a result still waits on a stalled output; a
// result that cannot be loaded holds the execute cycle until the output
// register frees up. push_enabled and occupancy_bytes follow the queue
// state as of the last word executed.
module partial_read_frame_fifo import prff_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // APB configuration
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [PADDR_W-1:0]     paddr,
  input  wire  [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready,
  // input words
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  [MODE_W-1:0]      mode_i,
  input  wire  [ADDR_BITS-1:0]   frame_addr_i,
  input  wire  [LEN_W-1:0]       frame_len_i,
  input  wire  [LEN_W-1:0]       need_len_i,
  // result words
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic                   accepted_o,
  output logic                   got_data_o,
  output logic [ADDR_BITS-1:0]   data_addr_o,
  output logic [LEN_W-1:0]       granted_len_o,
  output logic                   frame_done_o,
  output logic                   push_enabled_o,
  output logic [OCC_W-1:0]       occupancy_bytes_o
);

  logic [MAX_W-1:0] max_q;
  logic             cfg_we;
  cmd_t             cmd;

  // Register write on the access phase; paddr[2] selects the register,
  // low bits are the byte lane and ignored.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MAX_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_BYTES_RESET;
    end else if (cfg_we) begin
      max_q <= pwdata[MAX_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_BYTES) ? PDATA_W'(max_q) : '0;

  prff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  prff_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .max_bytes_i       (max_q),
    .mode_i            (mode_i),
    .frame_addr_i      (frame_addr_i),
    .frame_len_i       (frame_len_i),
    .need_len_i        (need_len_i),
    .accepted_o        (accepted_o),
    .got_data_o        (got_data_o),
    .data_addr_o       (data_addr_o),
    .granted_len_o     (granted_len_o),
    .frame_done_o      (frame_done_o),
    .push_enabled_o    (push_enabled_o),
    .occupancy_bytes_o (occupancy_bytes_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/prff_ctrl.sv =====
// Sequencer for the partial-read frame FIFO: input/output handshakes.
// Depends on prff_pkg; drives prff_dp through cmd_t.
`default_nettype none
module prff_ctrl import prff_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.capture = in_valid_i;
      ST_EXEC: cmd_o.exec    = !out_valid_q || !out_stall_i;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_EXEC))
    else $error("capture did not enter execute state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.exec)
    else $error("result overwritten while stalled");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/prff_dp.sv =====
// Datapath of the partial-read frame FIFO: descriptor memory, pointers,
// byte count and result register. Depends on prff_pkg; driven by prff_ctrl.
`default_nettype none
module prff_dp import prff_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  cmd_t                   cmd_i,
  input  wire  [MAX_W-1:0]       max_bytes_i,
  input  wire  [MODE_W-1:0]      mode_i,
  input  wire  [ADDR_BITS-1:0]   frame_addr_i,
  input  wire  [LEN_W-1:0]       frame_len_i,
  input  wire  [LEN_W-1:0]       need_len_i,
  output logic                   accepted_o,
  output logic                   got_data_o,
  output logic [ADDR_BITS-1:0]   data_addr_o,
  output logic [LEN_W-1:0]       granted_len_o,
  output logic                   frame_done_o,
  output logic                   push_enabled_o,
  output logic [OCC_W-1:0]       occupancy_bytes_o
);

  // captured word
  logic [MODE_W-1:0]    mode_q;
  logic [ADDR_BITS-1:0] faddr_q;
  logic [LEN_W-1:0]     flen_q;
  logic [LEN_W-1:0]     need_q;

  // descriptor store
  logic [ADDR_BITS-1:0] addr_mem [QUEUE_DEPTH];
  logic [LEN_W-1:0]     len_mem  [QUEUE_DEPTH];
  logic [ADDR_BITS-1:0] rd_addr_q;
  logic [LEN_W-1:0]     rd_len_q;

  // queue state
  ptr_t             head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [LEN_W-1:0] off_q, off_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic             push_q, push_d;

  // results
  logic                 res_acc_q, res_acc_d;
  logic                 res_got_q, res_got_d;
  logic [ADDR_BITS-1:0] res_addr_q, res_addr_d;
  logic [LEN_W-1:0]     res_gnt_q, res_gnt_d;
  logic                 res_done_q, res_done_d;

  logic                 enq_ok, deq_ok, pop, mem_we;
  logic [OCC_W-1:0]     occ_add, occ_sub;
  logic [LEN_W-1:0]     left;
  logic [ADDR_BITS-1:0] daddr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      faddr_q <= frame_addr_i;
      flen_q  <= frame_len_i;
      need_q  <= need_len_i;
    end
  end

  // head entry read every cycle; head only moves on exec, so it has
  // settled by the time the following word is captured
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      addr_mem[tail_q] <= faddr_q;
      len_mem[tail_q]  <= flen_q;
    end
    rd_addr_q <= addr_mem[head_q];
    rd_len_q  <= len_mem[head_q];
  end

  assign enq_ok  = push_q && (faddr_q != '0) && (flen_q != '0)
                   && (count_q < CNT_W'(QUEUE_DEPTH));
  assign occ_add = occ_q + OCC_W'(flen_q);
  assign deq_ok  = (count_q != '0);
  assign left    = (rd_len_q > off_q) ? (rd_len_q - off_q) : '0;
  assign pop     = (need_q >= left);
  assign occ_sub = (occ_q >= OCC_W'(rd_len_q)) ? (occ_q - OCC_W'(rd_len_q)) : '0;
  assign daddr   = rd_addr_q + ADDR_BITS'(off_q);
  assign mem_we  = cmd_i.exec && (mode_q == MODE_ENQ) && enq_ok;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    off_d      = off_q;
    occ_d      = occ_q;
    push_d     = push_q;
    res_acc_d  = 1'b0;
    res_got_d  = 1'b0;
    res_addr_d = '0;
    res_gnt_d  = '0;
    res_done_d = 1'b0;
    unique case (mode_q)
      MODE_ENQ: begin
        if (enq_ok) begin
          tail_d    = ptr_next(tail_q);
          count_d   = count_q + CNT_W'(1);
          occ_d     = occ_add;
          if (occ_add >= OCC_W'(max_bytes_i)) push_d = 1'b0;
          res_acc_d = 1'b1;
        end
      end
      MODE_DEQ: begin
        if (deq_ok) begin
          res_got_d  = 1'b1;
          res_addr_d = daddr;
          if (!pop) begin
            res_gnt_d = need_q;
            off_d     = off_q + need_q;
          end else begin
            res_gnt_d  = left;
            off_d      = '0;
            occ_d      = occ_sub;
            push_d     = 1'b1;
            head_d     = ptr_next(head_q);
            count_d    = count_q - CNT_W'(1);
            res_done_d = 1'b1;
          end
        end
      end
      MODE_FLUSH: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
        off_d   = '0;
        occ_d   = '0;
        push_d  = 1'b1;
      end
      default: begin
        // unused code: state untouched, status only
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      off_q   <= '0;
      occ_q   <= '0;
      push_q  <= 1'b1;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      off_q   <= off_d;
      occ_q   <= occ_d;
      push_q  <= push_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_acc_q  <= res_acc_d;
      res_got_q  <= res_got_d;
      res_addr_q <= res_addr_d;
      res_gnt_q  <= res_gnt_d;
      res_done_q <= res_done_d;
    end
  end

  // status fields track live state, which only moves on exec
  assign accepted_o        = res_acc_q;
  assign got_data_o        = res_got_q;
  assign data_addr_o       = res_addr_q;
  assign granted_len_o     = res_gnt_q;
  assign frame_done_o      = res_done_q;
  assign push_enabled_o    = push_q;
  assign occupancy_bytes_o = occ_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CNT_W'(QUEUE_DEPTH)) |-> (head_q == tail_q))
    else $error("pointers disagree with entry count");

  a_pop_reenables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && res_done_d) |=> push_q)
    else $error("pop left pushing disabled");
`endif

endmodule
`default_nettype wire
